>>> rtl/cls_pkg.sv
// shared types and constants for the cramer linear solver
`default_nettype none

package cls_pkg;

  localparam int OUT_W    = 53;
  localparam int NUM_UNK  = 3;
  localparam int NUM_COEF = 12;

  localparam logic [1:0] UNK_2X2   = 2'd2;
  localparam logic [1:0] UNK_RESET = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               singular;
    logic [NUM_UNK-1:0] neg;
  } side_t;

endpackage

`default_nettype wire

>>> rtl/cls_det.sv
// pipelined exact determinant and numerator evaluation
`default_nettype none

module cls_det
  import cls_pkg::*;
#(
  parameter int CW = 12,
  parameter int DW = 3 * CW + 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic                 mode2,
  input  wire logic signed [CW-1:0] coef [NUM_COEF],
  output logic                      out_valid,
  output logic signed [DW-1:0]      det,
  output logic signed [DW-1:0]      num [NUM_UNK]
);

  localparam int P1W = 2 * CW;
  localparam int MW  = 2 * CW + 1;
  localparam int P2W = 3 * CW + 1;

  // v index: a b cc k1 d e f k2 g h m k3
  logic signed [CW-1:0]  v_nxt [NUM_COEF];
  logic signed [CW-1:0]  v_r   [NUM_COEF];
  logic signed [CW-1:0]  top2_r [4];
  logic signed [CW-1:0]  top3_r [4];
  logic signed [P1W-1:0] pr_r  [12];
  logic signed [MW-1:0]  mn_r  [6];
  logic signed [P2W-1:0] t_r   [12];
  logic signed [DW-1:0]  det_r;
  logic signed [DW-1:0]  num_r [NUM_UNK];
  logic [4:0]            vld_r;

  // 2x2 embedded as a 3x3 system with third row z = 0
  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      v_nxt[i] = coef[i];
    end
    if (mode2) begin
      v_nxt[0]  = coef[0];
      v_nxt[1]  = coef[1];
      v_nxt[2]  = '0;
      v_nxt[3]  = coef[2];
      v_nxt[4]  = coef[3];
      v_nxt[5]  = coef[4];
      v_nxt[6]  = '0;
      v_nxt[7]  = coef[5];
      v_nxt[8]  = '0;
      v_nxt[9]  = '0;
      v_nxt[10] = CW'(1);
      v_nxt[11] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      // minor products
      pr_r[0]  <= P1W'(v_r[5])  * P1W'(v_r[10]);
      pr_r[1]  <= P1W'(v_r[6])  * P1W'(v_r[9]);
      pr_r[2]  <= P1W'(v_r[4])  * P1W'(v_r[10]);
      pr_r[3]  <= P1W'(v_r[6])  * P1W'(v_r[8]);
      pr_r[4]  <= P1W'(v_r[4])  * P1W'(v_r[9]);
      pr_r[5]  <= P1W'(v_r[5])  * P1W'(v_r[8]);
      pr_r[6]  <= P1W'(v_r[7])  * P1W'(v_r[10]);
      pr_r[7]  <= P1W'(v_r[6])  * P1W'(v_r[11]);
      pr_r[8]  <= P1W'(v_r[7])  * P1W'(v_r[9]);
      pr_r[9]  <= P1W'(v_r[5])  * P1W'(v_r[11]);
      pr_r[10] <= P1W'(v_r[4])  * P1W'(v_r[11]);
      pr_r[11] <= P1W'(v_r[7])  * P1W'(v_r[8]);
      for (int i = 0; i < 4; i++) begin
        top2_r[i] <= v_r[i];
        top3_r[i] <= top2_r[i];
      end
      for (int i = 0; i < 6; i++) begin
        mn_r[i] <= MW'(pr_r[2*i]) - MW'(pr_r[2*i+1]);
      end
      // mn: m1 m2 m3 p1 p2 p3 ; top3: a b cc k1
      t_r[0]  <= P2W'(top3_r[0]) * P2W'(mn_r[0]);
      t_r[1]  <= P2W'(top3_r[1]) * P2W'(mn_r[1]);
      t_r[2]  <= P2W'(top3_r[2]) * P2W'(mn_r[2]);
      t_r[3]  <= P2W'(top3_r[3]) * P2W'(mn_r[0]);
      t_r[4]  <= P2W'(top3_r[1]) * P2W'(mn_r[3]);
      t_r[5]  <= P2W'(top3_r[2]) * P2W'(mn_r[4]);
      t_r[6]  <= P2W'(top3_r[0]) * P2W'(mn_r[3]);
      t_r[7]  <= P2W'(top3_r[3]) * P2W'(mn_r[1]);
      t_r[8]  <= P2W'(top3_r[2]) * P2W'(mn_r[5]);
      t_r[9]  <= P2W'(top3_r[0]) * P2W'(mn_r[4]);
      t_r[10] <= P2W'(top3_r[1]) * P2W'(mn_r[5]);
      t_r[11] <= P2W'(top3_r[3]) * P2W'(mn_r[2]);
      det_r    <= DW'(t_r[0]) - DW'(t_r[1]) + DW'(t_r[2]);
      num_r[0] <= DW'(t_r[3]) - DW'(t_r[4]) + DW'(t_r[5]);
      num_r[1] <= DW'(t_r[6]) - DW'(t_r[7]) + DW'(t_r[8]);
      num_r[2] <= DW'(t_r[11]) - DW'(t_r[9]) - DW'(t_r[10]);
    end
  end

  assign out_valid = vld_r[4];
  assign det       = det_r;
  assign num       = num_r;

endmodule

`default_nettype wire

>>> rtl/cls_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes
`default_nettype none

module cls_div
  import cls_pkg::*;
#(
  parameter int DW = 39,
  parameter int FW = 16,
  parameter int QW = DW + FW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire side_t         in_side,
  input  wire logic [DW-1:0] d_mag,
  input  wire logic [DW-1:0] n_mag [NUM_UNK],
  output side_t              out_side,
  output logic [QW-1:0]      q [NUM_UNK]
);

  side_t       side_r [QW];
  logic [DW-1:0] d_r  [QW];
  logic [DW-1:0] r_r  [QW][NUM_UNK];
  logic [QW-1:0] nq_r [QW][NUM_UNK];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    side_t       side_nxt;
    logic [DW-1:0] d_in;
    logic [DW-1:0] r_in   [NUM_UNK];
    logic [QW-1:0] nq_in  [NUM_UNK];
    logic [DW-1:0] r_nxt  [NUM_UNK];
    logic [QW-1:0] nq_nxt [NUM_UNK];

    if (k == 0) begin : g_head
      always_comb begin
        side_nxt = in_side;
        d_in     = d_mag;
        for (int l = 0; l < NUM_UNK; l++) begin
          r_in[l]  = '0;
          nq_in[l] = QW'(n_mag[l]) << FW;
        end
      end
    end else begin : g_tail
      always_comb begin
        side_nxt = side_r[k-1];
        d_in     = d_r[k-1];
        for (int l = 0; l < NUM_UNK; l++) begin
          r_in[l]  = r_r[k-1][l];
          nq_in[l] = nq_r[k-1][l];
        end
      end
    end

    always_comb begin
      logic [DW:0] t;
      for (int l = 0; l < NUM_UNK; l++) begin
        t = {r_in[l], nq_in[l][QW-1]};
        if (t >= {1'b0, d_in}) begin
          r_nxt[l]  = DW'(t - {1'b0, d_in});
          nq_nxt[l] = {nq_in[l][QW-2:0], 1'b1};
        end else begin
          r_nxt[l]  = t[DW-1:0];
          nq_nxt[l] = {nq_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        side_r[k] <= side_nxt;
        d_r[k]    <= d_in;
        r_r[k]    <= r_nxt;
        nq_r[k]   <= nq_nxt;
      end
    end
  end

  assign out_side = side_r[QW-1];
  assign q        = nq_r[QW-1];

endmodule

`default_nettype wire

>>> rtl/cramer_linear_solver_core.sv
// top level: cramer's rule solver for 2x2 and 3x3 integer systems
// from input beat to result beat: determinant pipeline, magnitude register, divider stages, output register
// throughput: one system per cycle unless the result side stalls; the divider resolves one quotient bit per stage
// a stall on the result side freezes the whole pipeline, in_tready follows it
// reset (rst_n low, synchronous) clears all valid bits and sets unknowns_count to 3
`default_nettype none

module cramer_linear_solver_core
  import cls_pkg::*;
#(
  parameter int COEFF_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_wr_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // coef_r1_c1 .. coef_r3_c4 from bit 0 up
  input  wire logic [((NUM_COEF*COEFF_BITS+7)/8)*8-1:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // x_value, y_value, z_value from bit 0 up
  output logic [((NUM_UNK*OUT_W+7)/8)*8-1:0] out_tdata,
  // singular
  output logic [0:0]        out_tuser
);

  localparam int DW     = 3 * COEFF_BITS + 3;
  localparam int QW     = DW + FRAC_BITS;
  localparam int WW     = ((QW > OUT_W) ? QW : OUT_W) + 1;
  localparam int OUT_DW = ((NUM_UNK * OUT_W + 7) / 8) * 8;

  localparam logic [WW-1:0]    SAT_LIM = WW'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] MIN_MAG = OUT_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] MAX_MAG = MIN_MAG - OUT_W'(1);

  logic                        en;
  logic [1:0]                  unknowns_count_r;
  logic signed [COEFF_BITS-1:0] coef [NUM_COEF];
  logic                        det_valid;
  logic signed [DW-1:0]        det;
  logic signed [DW-1:0]        num [NUM_UNK];
  side_t                       abs_side_r;
  side_t                       abs_side_nxt;
  logic [DW-1:0]               d_mag_r;
  logic [DW-1:0]               n_mag_r [NUM_UNK];
  logic [DW-1:0]               n_mag_nxt [NUM_UNK];
  side_t                       div_side;
  logic [QW-1:0]               q [NUM_UNK];
  logic [OUT_W-1:0]            res_nxt [NUM_UNK];
  logic [OUT_W-1:0]            res_r [NUM_UNK];
  logic                        out_valid_r;
  logic                        singular_r;

  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unknowns_count_r <= UNK_RESET;
    end else if (cfg_wr_en) begin
      unknowns_count_r <= cfg_wr_data;
    end
  end

  for (genvar i = 0; i < NUM_COEF; i++) begin : g_unpack
    assign coef[i] = in_tdata[i*COEFF_BITS +: COEFF_BITS];
  end

  cls_det #(
    .CW (COEFF_BITS),
    .DW (DW)
  ) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .mode2     (unknowns_count_r == UNK_2X2),
    .coef      (coef),
    .out_valid (det_valid),
    .det       (det),
    .num       (num)
  );

  // magnitudes and signs
  always_comb begin
    abs_side_nxt.valid    = det_valid;
    abs_side_nxt.singular = (det == '0);
    for (int l = 0; l < NUM_UNK; l++) begin
      n_mag_nxt[l]        = num[l][DW-1] ? DW'(-num[l]) : DW'(num[l]);
      abs_side_nxt.neg[l] = num[l][DW-1] ^ det[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_side_r.valid <= 1'b0;
    end else if (en) begin
      abs_side_r <= abs_side_nxt;
      d_mag_r    <= det[DW-1] ? DW'(-det) : DW'(det);
      n_mag_r    <= n_mag_nxt;
    end
  end

  cls_div #(
    .DW (DW),
    .FW (FRAC_BITS),
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_side  (abs_side_r),
    .d_mag    (d_mag_r),
    .n_mag    (n_mag_r),
    .out_side (div_side),
    .q        (q)
  );

  // saturate and apply sign; singular results are forced to zero
  always_comb begin
    logic [WW-1:0]    qe;
    logic [OUT_W-1:0] mag;
    for (int l = 0; l < NUM_UNK; l++) begin
      qe = WW'(q[l]);
      if (qe >= SAT_LIM) begin
        mag = div_side.neg[l] ? MIN_MAG : MAX_MAG;
      end else begin
        mag = qe[OUT_W-1:0];
      end
      if (div_side.singular) begin
        res_nxt[l] = '0;
      end else begin
        res_nxt[l] = div_side.neg[l] ? OUT_W'(-mag) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= res_nxt;
      singular_r <= div_side.singular;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_DW'({res_r[2], res_r[1], res_r[0]});
  assign out_tuser[0] = singular_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("singular result not zero");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed during stall");

endmodule

`default_nettype wire

>>> test/tb_cramer_linear_solver_core.sv
// self-checking testbench for the cramer linear solver core
`default_nettype none

module tb_cramer_linear_solver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cls_pkg::*;

  localparam int CB = 12;
  localparam int FB = 16;
  localparam int IN_W = ((NUM_COEF*CB+7)/8)*8;
  localparam int RES_W = ((NUM_UNK*OUT_W+7)/8)*8;
  localparam int PIPE_LAT = 7 + 3*CB + 3 + FB;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coef_t;
  typedef logic signed [OUT_W-1:0] fix_t;

  typedef struct {
    fix_t x_val;
    fix_t y_val;
    fix_t z_val;
    logic sing;
  } solution_t;

  class solution_board;
    solution_t pending[$];
    logic [1:0] unk_mode;
    int errors;
    int checked;
    int singular_seen;

    function new();
      unk_mode = UNK_RESET;
      errors = 0;
      checked = 0;
      singular_seen = 0;
    endfunction

    function fix_t fixed_quot(longint num, longint den);
      longint unsigned n, d, ip, rem, frac, mag;
      bit neg;
      longint unsigned max_mag, min_mag;
      max_mag = (64'd1 << (OUT_W-1)) - 1;
      min_mag = 64'd1 << (OUT_W-1);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      neg = (num < 0) != (den < 0);
      ip = n / d;
      rem = n % d;
      frac = 0;
      for (int b = 0; b < FB; b++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= d) begin
          rem = rem - d;
          frac = frac | 1;
        end
      end
      if ((ip >> (OUT_W-1-FB)) != 0) mag = min_mag;
      else mag = (ip << FB) | frac;
      if (neg) begin
        if (mag > min_mag) mag = min_mag;
        return fix_t'(-mag);
      end
      if (mag > max_mag) mag = max_mag;
      return fix_t'(mag);
    endfunction

    function void note_system(logic [IN_W-1:0] beat);
      longint c[12];
      longint det, nx, ny, nz, m1, m2, m3;
      solution_t s;
      coef_t cv;
      for (int i = 0; i < 12; i++) begin
        cv = beat[i*CB +: CB];
        c[i] = cv;
      end
      if (unk_mode == UNK_2X2) begin
        det = c[0]*c[4] - c[1]*c[3];
        nx = c[2]*c[4] - c[1]*c[5];
        ny = c[0]*c[5] - c[2]*c[3];
        nz = 0;
      end else begin
        m1 = c[5]*c[10] - c[6]*c[9];
        m2 = c[4]*c[10] - c[6]*c[8];
        m3 = c[4]*c[9] - c[5]*c[8];
        det = c[0]*m1 - c[1]*m2 + c[2]*m3;
        nx = c[3]*m1 - c[1]*(c[7]*c[10] - c[6]*c[11])
             + c[2]*(c[7]*c[9] - c[5]*c[11]);
        ny = c[0]*(c[7]*c[10] - c[6]*c[11]) - c[3]*m2
             + c[2]*(c[4]*c[11] - c[7]*c[8]);
        nz = c[0]*(c[5]*c[11] - c[7]*c[9]) - c[1]*(c[4]*c[11] - c[7]*c[8])
             + c[3]*m3;
      end
      if (det == 0) begin
        s = '{0, 0, 0, 1'b1};
      end else begin
        s.x_val = fixed_quot(nx, det);
        s.y_val = fixed_quot(ny, det);
        s.z_val = (unk_mode == UNK_2X2) ? fix_t'(0) : fixed_quot(nz, det);
        s.sing = 1'b0;
      end
      pending.push_back(s);
    endfunction

    function void check_solution(logic [RES_W-1:0] data, logic sing);
      solution_t e;
      fix_t gx, gy, gz;
      gx = data[0 +: OUT_W];
      gy = data[OUT_W +: OUT_W];
      gz = data[2*OUT_W +: OUT_W];
      checked++;
      if (sing) singular_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d", $time, gx);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (gx !== e.x_val) begin
        $display("%0t: x expected %0d actual %0d", $time, e.x_val, gx);
        errors++;
      end
      if (gy !== e.y_val) begin
        $display("%0t: y expected %0d actual %0d", $time, e.y_val, gy);
        errors++;
      end
      if (gz !== e.z_val) begin
        $display("%0t: z expected %0d actual %0d", $time, e.z_val, gz);
        errors++;
      end
      if (sing !== e.sing) begin
        $display("%0t: singular expected %0b actual %0b", $time, e.sing, sing);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [1:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [RES_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  solution_board board;
  int send_idle_pct;
  int recv_idle_pct;
  longint cycles;
  int sent;

  cramer_linear_solver_core #(.COEFF_BITS(CB), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
  end

  // receiver side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready)
      board.check_solution(out_tdata, out_tuser[0]);
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] rand_system(int kind);
    logic [IN_W-1:0] v;
    coef_t cf;
    v = '0;
    for (int i = 0; i < 12; i++) begin
      case (kind)
        0: cf = coef_t'($urandom);
        1: cf = coef_t'($urandom_range(8) - 4);
        default: cf = $urandom_range(1) ? coef_t'(12'h800) : coef_t'(12'h7ff);
      endcase
      v[i*CB +: CB] = cf;
    end
    return v;
  endfunction

  // valid stays high after the beat so back to back beats need one drive each
  task automatic send_system(logic [IN_W-1:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_system(beat);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.unk_mode = m;
  endtask

  task automatic directed_set();
    logic [IN_W-1:0] v;
    send_system('0);
    send_system({(IN_W){1'b1}});
    v = '0;
    for (int i = 0; i < 12; i++) v[i*CB +: CB] = coef_t'(12'h800);
    send_system(v);
    v = '0;
    for (int i = 0; i < 12; i++) v[i*CB +: CB] = coef_t'(12'h7ff);
    send_system(v);
    // identity-like with large constants, and a huge quotient
    v = '0;
    v[0*CB +: CB] = coef_t'(1); v[5*CB +: CB] = coef_t'(1); v[10*CB +: CB] = coef_t'(1);
    v[4*CB +: CB] = coef_t'(1);
    v[2*CB +: CB] = coef_t'(12'h800); v[3*CB +: CB] = coef_t'(12'h7ff);
    v[7*CB +: CB] = coef_t'(12'h800); v[11*CB +: CB] = coef_t'(12'h7ff);
    send_system(v);
    v = '0;
    for (int i = 0; i < 12; i++) v[i*CB +: CB] = (i % 2) ? coef_t'(12'h7ff) : coef_t'(12'h800);
    send_system(v);
    for (int k = 0; k < 4; k++) send_system(rand_system(2));
    for (int k = 0; k < 4; k++) send_system(rand_system(1));
  endtask

  task automatic random_run(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(9);
      send_system(rand_system(r < 6 ? 0 : (r < 9 ? 1 : 2)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 2'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_set();
    write_mode(UNK_2X2);
    directed_set();
    write_mode(2'd0);
    send_system(rand_system(0));
    write_mode(2'd1);
    send_system(rand_system(1));

    send_idle_pct = 16; recv_idle_pct = 82;
    write_mode(UNK_2X2);
    random_run(70);
    drain();
    write_mode(UNK_RESET);
    random_run(80);

    send_idle_pct = 82; recv_idle_pct = 16;
    write_mode(UNK_2X2);
    random_run(70);
    write_mode(UNK_RESET);
    random_run(80);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_mode(UNK_2X2);
    random_run(60);
    write_mode(UNK_RESET);
    random_run(60);

    drain();
    $display("covered %0d systems in 2x2 and 3x3 modes, %0d results checked, %0d singular",
             sent, board.checked, board.singular_seen);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
rtl/cls_pkg.sv
rtl/cls_det.sv
rtl/cls_div.sv
rtl/cramer_linear_solver_core.sv
test/tb_cramer_linear_solver_core.sv
